FILE: sv/cpef_pkg.sv
// Package: types, sizes and codes of the coalescing pointer event FIFO.
package cpef_pkg;

    localparam int QUEUE_DEPTH = 256;
    localparam int SLOT_W      = $clog2(QUEUE_DEPTH);
    localparam int COUNT_W     = $clog2(QUEUE_DEPTH + 1);

    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_POP  = 1'b1;

    typedef enum logic [2:0] {
        ST_APPENDED  = 3'd0,
        ST_MERGED    = 3'd1,
        ST_DROPPED   = 3'd2,
        ST_POPPED    = 3'd3,
        ST_POP_EMPTY = 3'd4
    } status_t;

    typedef struct packed {
        logic        cmd;
        logic [14:0] pos_x;
        logic [14:0] pos_y;
        logic [7:0]  button_mask;
        logic        double_click;
    } req_t;

    typedef struct packed {
        logic [14:0] x;
        logic [14:0] y;
        logic [7:0]  buttons;
        logic        dbl;
    } event_t;

    localparam int EVENT_W = $bits(event_t);

    typedef struct packed {
        status_t            status;
        logic [14:0]        out_x;
        logic [14:0]        out_y;
        logic [7:0]         out_buttons;
        logic               out_double;
        logic [COUNT_W-1:0] fill_level;
    } result_t;

endpackage

FILE: sv/cpef_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module cpef_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: sv/coalescing_pointer_event_fifo.sv
// Top level: coalescing pointer event FIFO built on one event RAM.
//
// One request (push or pop) is taken on every cycle that start is high; busy
// never rises. The result shows on result, with done high, in the
// cycle after the request edge. Popped data come from the registered read
// port of the event RAM. The rate is one request per cycle, since each request
// touches one RAM slot and the counters. The receiver cannot stall, so it must
// take every result in that cycle. The event RAM is not cleared after reset;
// only written slots are ever read back.
module coalescing_pointer_event_fifo
    import cpef_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    output logic    busy,
    input  req_t    request,
    output logic    done,
    output result_t result
);

    logic [SLOT_W-1:0]  write_slot_reg, write_slot_next;
    logic [SLOT_W-1:0]  read_slot_reg, read_slot_next;
    logic [SLOT_W-1:0]  newest_slot_reg, newest_slot_next;
    logic [7:0]         newest_btn_reg, newest_btn_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic               done_reg;
    status_t            status_reg, status_next;

    logic               full;
    logic               empty;
    logic               we;
    logic [SLOT_W-1:0]  waddr;
    event_t             wdata;
    event_t             rdata;

    function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
        logic [SLOT_W-1:0] n;
        if (s == SLOT_W'(QUEUE_DEPTH - 1))
        begin
            n = '0;
        end
        else
        begin
            n = s + 1'b1;
        end
        return n;
    endfunction

    assign full  = (count_reg == COUNT_W'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);

    assign wdata.x       = request.pos_x;
    assign wdata.y       = request.pos_y;
    assign wdata.buttons = request.button_mask;
    assign wdata.dbl     = request.double_click;

    always_comb
    begin
        write_slot_next  = write_slot_reg;
        read_slot_next   = read_slot_reg;
        newest_slot_next = newest_slot_reg;
        newest_btn_next  = newest_btn_reg;
        count_next       = count_reg;
        status_next      = status_reg;
        we               = 1'b0;
        waddr            = write_slot_reg;
        if (start)
        begin
            if (request.cmd == CMD_PUSH)
            begin
                priority if (full)
                begin
                    status_next = ST_DROPPED;
                end
                else if (!empty && newest_btn_reg == request.button_mask)
                begin
                    // motion merge: overwrite newest entry in place
                    we          = 1'b1;
                    waddr       = newest_slot_reg;
                    status_next = ST_MERGED;
                end
                else
                begin
                    we               = 1'b1;
                    waddr            = write_slot_reg;
                    newest_slot_next = write_slot_reg;
                    newest_btn_next  = request.button_mask;
                    write_slot_next  = next_slot(write_slot_reg);
                    count_next       = count_reg + 1'b1;
                    status_next      = ST_APPENDED;
                end
            end
            else
            begin
                if (!empty)
                begin
                    read_slot_next = next_slot(read_slot_reg);
                    count_next     = count_reg - 1'b1;
                    status_next    = ST_POPPED;
                end
                else
                begin
                    status_next = ST_POP_EMPTY;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            write_slot_reg  <= '0;
            read_slot_reg   <= '0;
            newest_slot_reg <= '0;
            count_reg       <= '0;
            done_reg        <= 1'b0;
        end
        else
        begin
            write_slot_reg  <= write_slot_next;
            read_slot_reg   <= read_slot_next;
            newest_slot_reg <= newest_slot_next;
            count_reg       <= count_next;
            done_reg        <= start;
        end
    end

    always_ff @(posedge clk)
    begin
        newest_btn_reg <= newest_btn_next;
        status_reg     <= status_next;
    end

    cpef_ram #(
        .WIDTH(EVENT_W),
        .DEPTH(QUEUE_DEPTH)
    ) u_event_ram (
        .clk  (clk),
        .we   (we),
        .waddr(waddr),
        .wdata(wdata),
        .raddr(read_slot_reg),
        .rdata(rdata)
    );

    always_comb
    begin
        result.status      = status_reg;
        result.fill_level  = count_reg;
        result.out_x       = '0;
        result.out_y       = '0;
        result.out_buttons = '0;
        result.out_double  = 1'b0;
        if (status_reg == ST_POPPED)
        begin
            result.out_x       = rdata.x;
            result.out_y       = rdata.y;
            result.out_buttons = rdata.buttons;
            result.out_double  = rdata.dbl;
        end
    end

    assign done = done_reg;
    assign busy = 1'b0;

endmodule

FILE: bench/cpef_event_checker.sv
`timescale 1ns / 100ps
// Checker: predicts each pointer event FIFO result and compares it with the block's output.
module cpef_event_checker
    import cpef_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               busy,
    input  req_t               request,
    input  logic               done,
    input  result_t            result,
    output int unsigned        failures,
    output int unsigned        outstanding,
    output logic [4:0][15:0]   status_hits,
    output logic [COUNT_W-1:0] peak_fill
);

    event_t             shadow_events [QUEUE_DEPTH];
    logic [SLOT_W-1:0]  head_slot;
    logic [SLOT_W-1:0]  tail_slot;
    logic [SLOT_W-1:0]  last_slot;
    logic               last_valid;
    logic [COUNT_W-1:0] held;
    result_t            pending_results [$];
    int unsigned        mismatches;

    function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
        return (s == SLOT_W'(QUEUE_DEPTH - 1)) ? '0 : s + 1'b1;
    endfunction

    function automatic result_t predict_fifo_op(input req_t r);
        result_t res;
        event_t  ev;
        res          = '0;
        ev.x         = r.pos_x;
        ev.y         = r.pos_y;
        ev.buttons   = r.button_mask;
        ev.dbl       = r.double_click;
        if (r.cmd == CMD_PUSH)
        begin
            if (held == QUEUE_DEPTH)
            begin
                res.status = ST_DROPPED;
            end
            else if (last_valid && held != 0 &&
                     shadow_events[last_slot].buttons == r.button_mask)
            begin
                shadow_events[last_slot] = ev;
                res.status = ST_MERGED;
            end
            else
            begin
                shadow_events[tail_slot] = ev;
                last_slot  = tail_slot;
                last_valid = 1'b1;
                tail_slot  = next_slot(tail_slot);
                held       = held + 1'b1;
                res.status = ST_APPENDED;
            end
        end
        else if (held != 0)
        begin
            res.out_x       = shadow_events[head_slot].x;
            res.out_y       = shadow_events[head_slot].y;
            res.out_buttons = shadow_events[head_slot].buttons;
            res.out_double  = shadow_events[head_slot].dbl;
            head_slot       = next_slot(head_slot);
            held            = held - 1'b1;
            res.status      = ST_POPPED;
        end
        else
        begin
            res.status = ST_POP_EMPTY;
        end
        res.fill_level = held;
        return res;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want_v,
                               input logic [31:0] got_v);
        if (got_v !== want_v)
        begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want_v, got_v);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        result_t want;
        if (!rst_n)
        begin
            head_slot   = '0;
            tail_slot   = '0;
            last_slot   = '0;
            last_valid  = 1'b0;
            held        = '0;
            mismatches  = 0;
            pending_results.delete();
            failures    <= 0;
            outstanding <= 0;
            status_hits <= '0;
            peak_fill   <= '0;
        end
        else
        begin
            if (done)
            begin
                if (pending_results.size() == 0)
                begin
                    $display("%0t: unrequested result, expected none, got status %0d fill %0d",
                             $time, result.status, result.fill_level);
                    mismatches++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    check_field("status", want.status, result.status);
                    check_field("out_x", want.out_x, result.out_x);
                    check_field("out_y", want.out_y, result.out_y);
                    check_field("out_buttons", want.out_buttons, result.out_buttons);
                    check_field("out_double", want.out_double, result.out_double);
                    check_field("fill_level", want.fill_level, result.fill_level);
                end
            end
            if (start && !busy)
            begin
                want = predict_fifo_op(request);
                pending_results.push_back(want);
                status_hits[want.status] <= status_hits[want.status] + 1'b1;
                if (want.fill_level > peak_fill)
                    peak_fill <= want.fill_level;
            end
            failures    <= mismatches;
            outstanding <= pending_results.size();
        end
    end

endmodule

FILE: bench/tb_coalescing_pointer_event_fifo.sv
`timescale 1ns / 100ps
// Testbench top: drives push and pop requests into the pointer event FIFO and gives the verdict.
module tb_coalescing_pointer_event_fifo;
    import cpef_pkg::*;

    logic               clk   = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    req_t               request = '0;
    logic               busy;
    logic               done;
    result_t            result;
    int unsigned        failures;
    int unsigned        outstanding;
    logic [4:0][15:0]   status_hits;
    logic [COUNT_W-1:0] peak_fill;
    logic [7:0]         last_mask = '0;
    bit                 burst = 1'b0;
    int unsigned        sent = 0;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    coalescing_pointer_event_fifo dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .done    (done),
        .result  (result)
    );

    cpef_event_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .request     (request),
        .done        (done),
        .result      (result),
        .failures    (failures),
        .outstanding (outstanding),
        .status_hits (status_hits),
        .peak_fill   (peak_fill)
    );

    initial
    begin
        #2_000_000;
        $display("tb_coalescing_pointer_event_fifo failed");
        $finish;
    end

    function automatic req_t make_req(input logic c, input logic [14:0] x,
                                      input logic [14:0] y, input logic [7:0] m,
                                      input logic d);
        req_t r;
        r.cmd          = c;
        r.pos_x        = x;
        r.pos_y        = y;
        r.button_mask  = m;
        r.double_click = d;
        return r;
    endfunction

    // reuse_pct: chance that a push repeats the previous mask so it can merge
    function automatic req_t random_req(input bit is_push, input int reuse_pct);
        logic [7:0] m;
        m = ($urandom_range(0, 99) < reuse_pct) ? last_mask : 8'($urandom_range(0, 255));
        return make_req(is_push ? CMD_PUSH : CMD_POP, 15'($urandom_range(0, 32767)),
                        15'($urandom_range(0, 32767)), m, 1'($urandom_range(0, 1)));
    endfunction

    task automatic send_request(input req_t r);
        int gap;
        if ($urandom_range(0, 31) == 0)
            burst = !burst;
        gap = burst ? 0 : $urandom_range(0, 6);
        if (r.cmd == CMD_PUSH)
            last_mask = r.button_mask;
        start   <= 1'b1;
        request <= r;
        do @(posedge clk); while (busy);
        sent++;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_idle(input int limit);
        int n = 0;
        start <= 1'b0;
        do
        begin
            @(posedge clk);
            n++;
        end
        while (outstanding != 0 && n < limit);
    endtask

    task automatic run_phase(input int count, input int push_pct, input int reuse_pct);
        repeat (count)
            send_request(random_req($urandom_range(0, 99) < push_pct, reuse_pct));
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_request(make_req(CMD_POP,  15'h0000, 15'h0000, 8'h00, 1'b0));
        send_request(make_req(CMD_PUSH, 15'h0000, 15'h0000, 8'h00, 1'b0));
        send_request(make_req(CMD_PUSH, 15'h7fff, 15'h7fff, 8'h00, 1'b1));
        send_request(make_req(CMD_PUSH, 15'h7fff, 15'h0000, 8'hff, 1'b0));
        send_request(make_req(CMD_PUSH, 15'h0000, 15'h7fff, 8'hff, 1'b1));
        // mask matches an older entry, not the newest one
        send_request(make_req(CMD_PUSH, 15'h1234, 15'h4321, 8'h00, 1'b0));
        send_request(make_req(CMD_PUSH, 15'h2aaa, 15'h5555, 8'ha5, 1'b1));
        repeat (4)
            send_request(make_req(CMD_POP, 15'h0000, 15'h0000, 8'h00, 1'b0));
        send_request(make_req(CMD_POP,  15'h7fff, 15'h7fff, 8'hff, 1'b1));
        // empty queue with a stale newest entry of the same mask: must append
        send_request(make_req(CMD_PUSH, 15'h5555, 15'h2aaa, 8'ha5, 1'b0));
        send_request(make_req(CMD_PUSH, 15'h0001, 15'h0001, 8'h5a, 1'b1));
        repeat (3)
            send_request(make_req(CMD_POP, 15'h0000, 15'h0000, 8'h00, 1'b0));
        wait_idle(50);

        run_phase(60, 50, 40);
        run_phase(320, 97, 8);
        wait_idle(50);
        run_phase(330, 90, 50);
        wait_idle(50);
        repeat (3) @(posedge clk);

        $display("covered %0d requests: %0d appended, %0d merged, %0d dropped on full,",
                 sent, status_hits[ST_APPENDED], status_hits[ST_MERGED],
                 status_hits[ST_DROPPED]);
        $display("%0d popped, %0d popped while empty; highest fill level %0d of %0d",
                 status_hits[ST_POPPED], status_hits[ST_POP_EMPTY], peak_fill, QUEUE_DEPTH);
        if (outstanding != 0)
            $display("%0t: %0d results never arrived", $time, outstanding);
        if (failures == 0 && outstanding == 0)
            $display("tb_coalescing_pointer_event_fifo passed");
        else
            $display("tb_coalescing_pointer_event_fifo failed");
        $finish;
    end

endmodule
